[hw/rtl/fm_tuner_mute_volume_controller_unit_assert.svh]
// Assertion macros for the checker file
`ifndef FM_TUNER_MUTE_VOLUME_CONTROLLER_UNIT_ASSERT_SVH
`define FM_TUNER_MUTE_VOLUME_CONTROLLER_UNIT_ASSERT_SVH
// a implies b on the same edge
`define FMT_ASSERT_IMP(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");
// a implies b on the next edge
`define FMT_ASSERT_NXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");
`endif

[hw/rtl/fmt_pkg.sv]
// ----------------------------------------------------------------------------
// fmt_pkg
// Types, codes and constants for the tuner control block.
// ----------------------------------------------------------------------------
`default_nettype none
package fmt_pkg;
  localparam logic [1:0] REQ_FREQ   = 2'd0;
  localparam logic [1:0] REQ_VOL    = 2'd1;
  localparam logic [1:0] REQ_MUTE   = 2'd2;
  localparam logic [1:0] REQ_STATUS = 2'd3;

  localparam logic [1:0] CFG_ADDR_MUTE_FREQ = 2'd0;

  localparam logic [20:0] MUTE_FREQ_RST = 21'd1400000;
  localparam logic [3:0]  OFF_VOL_HI = 4'd0;
  localparam logic [3:0]  OFF_VOL_LO = 4'd2;
  localparam logic [3:0]  OFF_TUNE_A = 4'd4;
  localparam logic [3:0]  OFF_TUNE_B = 4'd6;
  localparam logic [3:0]  OFF_TUNE_C = 4'd8;

  // rounded-up reciprocals, exact for the operand ranges of each step:
  // f < 2^21 (shift 29), x*x+2500 < 2^28 (shift 41), w*x+5000 < 2^29
  // (shift 43), 10*x*x+10433 < 2^31 (shift 46)
  localparam logic [31:0] RCP_160   = 32'(((64'd1 << 29) + 64'd159) / 64'd160);
  localparam logic [31:0] RCP_5000  = 32'(((64'd1 << 41) + 64'd4999) / 64'd5000);
  localparam logic [31:0] RCP_10000 = 32'(((64'd1 << 43) + 64'd9999) / 64'd10000);
  localparam logic [31:0] RCP_20866 = 32'(((64'd1 << 46) + 64'd20865) / 64'd20866);

  typedef struct packed {
    logic [1:0]  req_type;
    logic [20:0] frequency_value;
    logic [15:0] volume_level;
    logic        mute_on;
  } in_item_t;

  typedef struct packed {
    logic        is_write;
    logic [3:0]  port_offset;
    logic [7:0]  port_data;
    logic        muted_now;
    logic [15:0] volume_now;
    logic [20:0] frequency_now;
    logic        last;
  } out_item_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_DIV, ST_SQ, ST_Q1, ST_WX, ST_Q2, ST_TX, ST_Q3, ST_SUM,
    ST_EMIT, ST_WAIT
  } state_t;

  // arithmetic steps of the tuning polynomial
  typedef enum logic [2:0] {
    SP_DIV, SP_SQ, SP_Q1, SP_WX, SP_Q2, SP_TX, SP_Q3, SP_SUM
  } step_t;

  // microcode for one emitted transfer
  typedef enum logic [2:0] {
    EM_VHI, EM_VLO, EM_TA, EM_TB, EM_TC, EM_STAT
  } emit_t;

  // controller -> datapath
  typedef struct packed {
    logic       load;        // capture request, plan sequence
    step_t      step;        // arithmetic step (state-driven)
    logic       step_en;
    logic       emit;        // present current sequence entry
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic need_tune;
    logic none;
    logic seq_last;
    logic out_busy;
  } sts_t;
endpackage
`default_nettype wire

[hw/rtl/fmt_ctrl.sv]
// ----------------------------------------------------------------------------
// fmt_ctrl
// Sequencer: steps the tuning arithmetic and paces result transfers.
// ----------------------------------------------------------------------------
`default_nettype none
module fmt_ctrl import fmt_pkg::*; (
  input  wire  logic clk,
  input  wire  logic rst_n,
  input  wire  logic in_fire,
  input  wire  sts_t sts,
  output logic       ready,
  output cmd_t       cmd
);
  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_fire) state_nxt = ST_WAIT;
      ST_WAIT: begin
        if (sts.none)           state_nxt = ST_IDLE;
        else if (sts.need_tune) state_nxt = ST_DIV;
        else                    state_nxt = ST_EMIT;
      end
      ST_DIV:  state_nxt = ST_SQ;
      ST_SQ:   state_nxt = ST_Q1;
      ST_Q1:   state_nxt = ST_WX;
      ST_WX:   state_nxt = ST_Q2;
      ST_Q2:   state_nxt = ST_TX;
      ST_TX:   state_nxt = ST_Q3;
      ST_Q3:   state_nxt = ST_SUM;
      ST_SUM:  state_nxt = ST_EMIT;
      ST_EMIT: if (!sts.out_busy && sts.seq_last) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    ready = (state_r == ST_IDLE);
    cmd.load = in_fire;
    case (state_r)
      ST_DIV: begin cmd.step_en = 1'b1; cmd.step = SP_DIV; end
      ST_SQ:  begin cmd.step_en = 1'b1; cmd.step = SP_SQ;  end
      ST_Q1:  begin cmd.step_en = 1'b1; cmd.step = SP_Q1;  end
      ST_WX:  begin cmd.step_en = 1'b1; cmd.step = SP_WX;  end
      ST_Q2:  begin cmd.step_en = 1'b1; cmd.step = SP_Q2;  end
      ST_TX:  begin cmd.step_en = 1'b1; cmd.step = SP_TX;  end
      ST_Q3:  begin cmd.step_en = 1'b1; cmd.step = SP_Q3;  end
      ST_SUM: begin cmd.step_en = 1'b1; cmd.step = SP_SUM; end
      ST_EMIT: cmd.emit = !sts.out_busy;
      default: ;
    endcase
  end
endmodule
`default_nettype wire

[hw/rtl/fmt_dp.sv]
// ----------------------------------------------------------------------------
// fmt_dp
// Datapath: request state, tuning polynomial, transfer list, output register.
// ----------------------------------------------------------------------------
`default_nettype none
module fmt_dp import fmt_pkg::*; (
  input  wire  logic      clk,
  input  wire  logic      rst_n,
  input  wire  in_item_t  in_data,
  input  wire  logic [20:0] mute_freq,
  input  wire  cmd_t      cmd,
  input  wire  logic      out_stall,
  output sts_t            sts,
  output logic            out_valid,
  output out_item_t       out_data
);
  logic        muted_r, muted_nxt;
  logic [15:0] vol_r, vol_nxt;
  logic [20:0] freq_r, freq_nxt;
  logic [20:0] tfreq_r, tfreq_nxt;
  logic [1:0]  vbits_r, vbits_nxt;
  emit_t       seq_r [5];
  emit_t       seq_nxt [5];
  logic [2:0]  cnt_r, cnt_nxt;
  logic [2:0]  len_r, len_nxt;
  logic        tune_r, tune_nxt;
  logic        stat_r, stat_nxt;
  logic [31:0] x_r, a_r, w_r;
  logic [63:0] prod;
  logic [31:0] mul_a, mul_b;
  out_item_t   obuf_r;
  logic        ovalid_r;
  logic        planned_r;

  // two-term multiply, registered in x_r, a_r or w_r by step
  assign prod = 64'(mul_a) * 64'(mul_b);

  always_comb begin
    muted_nxt = muted_r; vol_nxt = vol_r; freq_nxt = freq_r;
    tfreq_nxt = tfreq_r; vbits_nxt = vbits_r; len_nxt = 3'd0;
    tune_nxt = 1'b0; stat_nxt = 1'b0;
    for (int i = 0; i < 5; i++) seq_nxt[i] = EM_STAT;
    case (in_data.req_type)
      REQ_FREQ: begin
        tfreq_nxt = in_data.frequency_value; freq_nxt = in_data.frequency_value;
        seq_nxt[0] = EM_TA; seq_nxt[1] = EM_TB; seq_nxt[2] = EM_TC;
        len_nxt = 3'd3; tune_nxt = 1'b1;
      end
      REQ_VOL: begin
        if (muted_r && in_data.volume_level != 16'd0) begin
          vol_nxt = in_data.volume_level; muted_nxt = 1'b0;
          tfreq_nxt = freq_r; vbits_nxt = in_data.volume_level[15:14];
          seq_nxt[0] = EM_TA; seq_nxt[1] = EM_TB; seq_nxt[2] = EM_TC;
          seq_nxt[3] = EM_VHI; seq_nxt[4] = EM_VLO;
          len_nxt = 3'd5; tune_nxt = 1'b1;
        end else if (in_data.volume_level == vol_r) begin
          len_nxt = 3'd0;
        end else if (in_data.volume_level == 16'd0) begin
          vol_nxt = 16'd0;
          if (!muted_r) begin
            muted_nxt = 1'b1; tfreq_nxt = mute_freq; vbits_nxt = 2'd0;
            seq_nxt[0] = EM_VHI; seq_nxt[1] = EM_VLO; seq_nxt[2] = EM_TA;
            seq_nxt[3] = EM_TB; seq_nxt[4] = EM_TC;
            len_nxt = 3'd5; tune_nxt = 1'b1;
          end
        end else begin
          vol_nxt = in_data.volume_level; vbits_nxt = in_data.volume_level[15:14];
          seq_nxt[0] = EM_VHI; seq_nxt[1] = EM_VLO; len_nxt = 3'd2;
        end
      end
      REQ_MUTE: begin
        if (in_data.mute_on && !muted_r) begin
          muted_nxt = 1'b1; tfreq_nxt = mute_freq; vbits_nxt = 2'd0;
          seq_nxt[0] = EM_VHI; seq_nxt[1] = EM_VLO; seq_nxt[2] = EM_TA;
          seq_nxt[3] = EM_TB; seq_nxt[4] = EM_TC;
          len_nxt = 3'd5; tune_nxt = 1'b1;
        end else if (!in_data.mute_on && muted_r) begin
          muted_nxt = 1'b0; tfreq_nxt = freq_r; vbits_nxt = vol_r[15:14];
          seq_nxt[0] = EM_TA; seq_nxt[1] = EM_TB; seq_nxt[2] = EM_TC;
          seq_nxt[3] = EM_VHI; seq_nxt[4] = EM_VLO;
          len_nxt = 3'd5; tune_nxt = 1'b1;
        end
      end
      default: begin
        seq_nxt[0] = EM_STAT; len_nxt = 3'd1; stat_nxt = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      muted_r <= 1'b0; vol_r <= '0; freq_r <= '0; len_r <= '0;
      cnt_r <= '0; planned_r <= 1'b0;
    end else begin
      planned_r <= cmd.load;
      if (cmd.load) begin
        muted_r <= muted_nxt; vol_r <= vol_nxt; freq_r <= freq_nxt;
        len_r <= len_nxt; cnt_r <= '0;
      end else if (cmd.emit) begin
        cnt_r <= cnt_nxt;
      end
    end
  end

  assign cnt_nxt = cnt_r + 3'd1;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      tfreq_r <= tfreq_nxt; vbits_r <= vbits_nxt; tune_r <= tune_nxt;
      stat_r <= stat_nxt;
      for (int i = 0; i < 5; i++) seq_r[i] <= seq_nxt[i];
    end
  end

  // polynomial steps; constant divides are reciprocal multiplies through
  // the shared multiplier, keeping the upper product bits
  always_comb begin
    mul_a = x_r; mul_b = x_r;
    case (cmd.step)
      SP_DIV: begin mul_a = {11'd0, tfreq_r}; mul_b = RCP_160; end
      SP_SQ:  begin mul_a = x_r; mul_b = x_r; end
      SP_Q1:  begin mul_a = a_r; mul_b = RCP_5000; end
      SP_WX:  begin mul_a = w_r; mul_b = x_r; end
      SP_Q2:  begin mul_a = a_r; mul_b = RCP_10000; end
      SP_TX:  begin mul_a = x_r; mul_b = (x_r << 3) + (x_r << 1); end
      SP_Q3:  begin mul_a = a_r; mul_b = RCP_20866; end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.step_en) begin
      case (cmd.step)
        SP_DIV: x_r <= prod[60:29];
        SP_SQ:  a_r <= prod[31:0] + 32'd2500;
        SP_Q1:  w_r <= {9'd0, prod[63:41]};
        SP_WX:  a_r <= prod[31:0] + 32'd5000;
        SP_Q2:  w_r <= {11'd0, prod[63:43]};
        SP_TX:  a_r <= prod[31:0] + 32'd10433;
        SP_Q3:  w_r <= w_r - {14'd0, prod[63:46]};
        SP_SUM: w_r <= w_r + (x_r << 2) - 32'd11505;
        default: ;
      endcase
    end
  end

  always_comb begin
    sts.need_tune = tune_r;
    sts.none      = planned_r && (len_r == 3'd0);
    sts.seq_last  = (cnt_nxt == len_r);
    sts.out_busy  = ovalid_r && out_stall;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) ovalid_r <= 1'b0;
    else if (cmd.emit) ovalid_r <= 1'b1;
    else if (!out_stall) ovalid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      obuf_r.is_write      <= !stat_r;
      obuf_r.muted_now     <= muted_r;
      obuf_r.volume_now    <= vol_r;
      obuf_r.frequency_now <= freq_r;
      obuf_r.last          <= (cnt_nxt == len_r);
      case (seq_r[cnt_r])
        EM_VHI: begin
          obuf_r.port_offset <= OFF_VOL_HI; obuf_r.port_data <= {7'd0, vbits_r[1]};
        end
        EM_VLO: begin
          obuf_r.port_offset <= OFF_VOL_LO; obuf_r.port_data <= {7'd0, vbits_r[0]};
        end
        EM_TA: begin
          obuf_r.port_offset <= OFF_TUNE_A; obuf_r.port_data <= {7'd0, w_r[8]};
        end
        EM_TB: begin
          obuf_r.port_offset <= OFF_TUNE_B; obuf_r.port_data <= w_r[16:9];
        end
        EM_TC: begin
          obuf_r.port_offset <= OFF_TUNE_C; obuf_r.port_data <= w_r[7:0];
        end
        default: begin
          obuf_r.port_offset <= OFF_VOL_HI; obuf_r.port_data <= 8'd0;
        end
      endcase
    end
  end

  assign out_valid = ovalid_r;
  assign out_data  = obuf_r;
endmodule
`default_nettype wire

[hw/rtl/fm_tuner_mute_volume_controller_unit.sv]
// One request at a time: in_stall stays high until the sequencer has stepped
// the tuning polynomial through one shared multiplier, where a retune is
// needed, and then issued one result per cycle while the receiver does not stall.
// Requests with no result return to idle without issuing one.
// Reset (rst_n, synchronous): state clears, mute_frequency = 1400000.
// ----------------------------------------------------------------------------
// fm_tuner_mute_volume_controller_unit
// Top level: APB register, sequencer and datapath.
// ----------------------------------------------------------------------------
`default_nettype none
module fm_tuner_mute_volume_controller_unit import fmt_pkg::*; (
  input  wire  logic        clk,
  input  wire  logic        rst_n,
  input  wire  logic        in_valid,
  output logic              in_stall,
  input  wire  in_item_t    in_data,
  output logic              out_valid,
  input  wire  logic        out_stall,
  output out_item_t         out_data,
  input  wire  logic        cfg_psel,
  input  wire  logic        cfg_penable,
  input  wire  logic        cfg_pwrite,
  input  wire  logic [1:0]  cfg_paddr,
  input  wire  logic [31:0] cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);
  logic [20:0] mute_freq_r;
  logic        ready, in_fire;
  cmd_t        cmd;
  sts_t        sts;

  assign cfg_pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) mute_freq_r <= MUTE_FREQ_RST;
    else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == CFG_ADDR_MUTE_FREQ)
      mute_freq_r <= cfg_pwdata[20:0];
  end
  assign cfg_prdata = (cfg_paddr == CFG_ADDR_MUTE_FREQ) ? {11'd0, mute_freq_r} : 32'd0;

  assign in_stall = !ready;
  assign in_fire  = in_valid && ready;

  fmt_ctrl u_ctrl (.clk, .rst_n, .in_fire, .sts, .ready, .cmd);
  fmt_dp u_dp (.clk, .rst_n, .in_data, .mute_freq(mute_freq_r), .cmd, .out_stall,
    .sts, .out_valid, .out_data);
endmodule
`default_nettype wire

[hw/rtl/fmt_checker.sv]
// ----------------------------------------------------------------------------
// fmt_checker
// Port-level checks, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "fm_tuner_mute_volume_controller_unit_assert.svh"
module fmt_checker import fmt_pkg::*; (
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_stall,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire out_item_t out_data
);
  `FMT_ASSERT_NXT(a_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data))
  `FMT_ASSERT_IMP(a_stat, clk, rst_n, out_valid && !out_data.is_write, out_data.last)
  `FMT_ASSERT_NXT(a_busy, clk, rst_n, in_valid && !in_stall, in_stall)
  `FMT_ASSERT_IMP(a_off, clk, rst_n, out_valid, out_data.port_offset[0] == 1'b0)
endmodule
bind fm_tuner_mute_volume_controller_unit fmt_checker u_chk (.clk, .rst_n, .in_valid,
  .in_stall, .out_valid, .out_stall, .out_data);
`default_nettype wire

[test/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Checks the tuner control block against a cycle-free model of its request
// handling: random and directed requests, APB writes of the mute frequency,
// random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import fmt_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_data;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [1:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  fm_tuner_mute_volume_controller_unit dut (.*);

  class tuner_scoreboard;
    logic [20:0] mute_freq;
    logic        muted;
    logic [15:0] volume;
    logic [20:0] frequency;
    out_item_t   pending_writes[$];
    int          errors;

    function new();
      mute_freq = MUTE_FREQ_RST;
      muted = 1'b0;
      volume = '0;
      frequency = '0;
      errors = 0;
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
      errors++;
    endtask

    function void push(logic [3:0] off, logic [7:0] dat, ref out_item_t buf_q[$]);
      out_item_t o;
      o = '0;
      o.is_write = 1'b1;
      o.port_offset = off;
      o.port_data = dat;
      buf_q.push_back(o);
    endfunction

    // 32-bit wrapping polynomial, as the tuner expects
    function void tune(logic [20:0] f, ref out_item_t buf_q[$]);
      bit [31:0] x, w;
      x = 32'(f) / 32'd160;
      w = (x * x + 32'd2500) / 32'd5000;
      w = (w * x + 32'd5000) / 32'd10000;
      w = w - (32'd10 * x * x + 32'd10433) / 32'd20866;
      w = w + 32'd4 * x - 32'd11505;
      push(OFF_TUNE_A, {7'd0, w[8]}, buf_q);
      push(OFF_TUNE_B, w[16:9], buf_q);
      push(OFF_TUNE_C, w[7:0], buf_q);
    endfunction

    function void vol_write(logic [15:0] v, ref out_item_t buf_q[$]);
      push(OFF_VOL_HI, {7'd0, v[15]}, buf_q);
      push(OFF_VOL_LO, {7'd0, v[14]}, buf_q);
    endfunction

    function void go_mute(ref out_item_t buf_q[$]);
      if (!muted) begin
        vol_write('0, buf_q);
        tune(mute_freq, buf_q);
        muted = 1'b1;
      end
    endfunction

    function void go_unmute(ref out_item_t buf_q[$]);
      if (muted) begin
        tune(frequency, buf_q);
        vol_write(volume, buf_q);
        muted = 1'b0;
      end
    endfunction

    function void note_request(in_item_t req);
      out_item_t seq[$];
      out_item_t o;
      case (req.req_type)
        REQ_FREQ: begin
          tune(req.frequency_value, seq);
          frequency = req.frequency_value;
        end
        REQ_VOL: begin
          if (muted && req.volume_level != 0) begin
            volume = req.volume_level;
            go_unmute(seq);
          end else if (req.volume_level == volume) begin
          end else if (req.volume_level == 0) begin
            go_mute(seq);
            volume = '0;
          end else begin
            vol_write(req.volume_level, seq);
            volume = req.volume_level;
          end
        end
        REQ_MUTE: begin
          if (req.mute_on) go_mute(seq);
          else go_unmute(seq);
        end
        default: begin
          o = '0;
          seq.push_back(o);
        end
      endcase
      foreach (seq[k]) begin
        o = seq[k];
        o.muted_now = muted;
        o.volume_now = volume;
        o.frequency_now = frequency;
        o.last = (k == seq.size() - 1);
        pending_writes.push_back(o);
      end
    endfunction

    task check_result(out_item_t got);
      out_item_t want;
      if (pending_writes.size() == 0) begin
        report("unexpected transfer", 32'(got), 32'd0);
      end else begin
        want = pending_writes.pop_front();
        if (got.is_write != want.is_write)
          report("is_write", 32'(got.is_write), 32'(want.is_write));
        if (got.port_offset != want.port_offset)
          report("port_offset", 32'(got.port_offset), 32'(want.port_offset));
        if (got.port_data != want.port_data)
          report("port_data", 32'(got.port_data), 32'(want.port_data));
        if (got.muted_now != want.muted_now)
          report("muted_now", 32'(got.muted_now), 32'(want.muted_now));
        if (got.volume_now != want.volume_now)
          report("volume_now", 32'(got.volume_now), 32'(want.volume_now));
        if (got.frequency_now != want.frequency_now)
          report("frequency_now", 32'(got.frequency_now), 32'(want.frequency_now));
        if (got.last != want.last) report("last", 32'(got.last), 32'(want.last));
      end
    endtask
  endclass

  tuner_scoreboard sb;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_cycles;
  int cycles;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout");
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk)
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);

  // receiver: long hold-off when requested, else random stalls
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task send(in_item_t item);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (in_stall);
    sb.note_request(item);
    @(negedge clk);
  endtask

  task send_fields(logic [1:0] rt, logic [20:0] f, logic [15:0] v, logic m);
    in_item_t item;
    item.req_type = rt;
    item.frequency_value = f;
    item.volume_level = v;
    item.mute_on = m;
    send(item);
  endtask

  task drain();
    in_valid <= 1'b0;
    while (sb.pending_writes.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task write_mute_freq(logic [20:0] f);
    drain();
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= CFG_ADDR_MUTE_FREQ;
    cfg_pwdata <= {11'd0, f};
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    sb.mute_freq = f;
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  function logic [15:0] pick_volume();
    case ($urandom_range(4))
      0: return '0;
      1: return sb.volume;
      2: return {2'($urandom_range(3)), 14'd0};
      default: return 16'($urandom);
    endcase
  endfunction

  function logic [20:0] pick_freq();
    if ($urandom_range(1)) return 21'($urandom_range(1736000, 1392000));
    return 21'($urandom);
  endfunction

  task random_requests(int n);
    int i;
    logic [1:0] rt;
    for (i = 0; i < n; i++) begin
      case ($urandom_range(9))
        0, 1: rt = REQ_FREQ;
        2, 3, 4, 5: rt = REQ_VOL;
        6, 7, 8: rt = REQ_MUTE;
        default: rt = REQ_STATUS;
      endcase
      send_fields(rt, pick_freq(), pick_volume(), 1'($urandom));
    end
  endtask

  initial begin
    int ph;
    sb = new();
    cycles = 0;
    hold_cycles = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: extremes, every request kind, no-op cases
    send_fields(REQ_STATUS, '1, '1, 1'b1);
    send_fields(REQ_VOL, '1, 16'd0, 1'b0);       // equal to stored: nothing
    send_fields(REQ_FREQ, 21'd0, '0, 1'b0);
    send_fields(REQ_FREQ, 21'h1FFFFF, '0, 1'b0);
    send_fields(REQ_FREQ, 21'd160, '0, 1'b0);
    send_fields(REQ_VOL, '0, 16'hFFFF, 1'b0);
    send_fields(REQ_VOL, '0, 16'hFFFF, 1'b0);    // repeat: nothing
    send_fields(REQ_VOL, '0, 16'h4000, 1'b0);
    send_fields(REQ_MUTE, '0, '0, 1'b0);         // unmute while not muted
    send_fields(REQ_MUTE, '0, '0, 1'b1);
    send_fields(REQ_MUTE, '0, '0, 1'b1);         // already muted
    send_fields(REQ_FREQ, 21'd1500000, '0, 1'b0); // retunes while muted
    send_fields(REQ_VOL, '0, 16'h8000, 1'b0);    // unmutes
    send_fields(REQ_VOL, '0, 16'd0, 1'b0);       // mutes
    send_fields(REQ_VOL, '0, 16'd0, 1'b0);
    send_fields(REQ_MUTE, '0, '0, 1'b0);
    send_fields(REQ_STATUS, '0, '0, 1'b0);

    write_mute_freq(21'd1392000);
    send_fields(REQ_MUTE, '0, '0, 1'b1);
    send_fields(REQ_MUTE, '0, '0, 1'b0);
    write_mute_freq(21'd1736000);
    send_fields(REQ_MUTE, '0, '0, 1'b1);
    send_fields(REQ_MUTE, '0, '0, 1'b0);

    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
        default: begin send_idle_pct = 23; recv_stall_pct = 23; end
      endcase
      write_mute_freq(21'($urandom_range(1736000, 1392000)));
      random_requests(30);
    end

    // back-pressure: receiver holds off while requests keep coming
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_cycles = 300;
    random_requests(12);
    drain();
    random_requests(10);
    write_mute_freq(MUTE_FREQ_RST);
    random_requests(10);

    drain();
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
`default_nettype wire
